// ===== rtl/core/gspq_pkg.sv =====
package gspq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int ACTION_COUNT = 32;
  localparam int STATE_COUNT  = 32;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 5;
  localparam int PRIO_W   = 8;
  localparam int QCNT_W   = 5;
  localparam int ACNT_W   = 6;

  localparam int LEN_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W   = $clog2(QUEUE_DEPTH);
  localparam int ACT_IDX_W = (ACTION_COUNT > 1) ? $clog2(ACTION_COUNT) : 1;
  localparam int ST_IDX_W = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
  localparam int BLK_W    = $clog2(STATE_COUNT + 1);
  localparam int AID_EXT_W = (ACT_IDX_W > ID_W) ? ACT_IDX_W : ID_W;
  localparam int SID_EXT_W = (ST_IDX_W > ID_W) ? ST_IDX_W : ID_W;

  localparam logic [AID_EXT_W:0] ACTION_LIMIT = (AID_EXT_W + 1)'(ACTION_COUNT);
  localparam logic [SID_EXT_W:0] STATE_LIMIT  = (SID_EXT_W + 1)'(STATE_COUNT);

  localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_ATTR = 2'd3;

  typedef struct packed {
    logic              le;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } gspq_link_t;

  typedef struct packed {
    logic              ins_en;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } gspq_bcast_t;

endpackage

// ===== rtl/core/gspq_if.sv =====
interface gspq_in_if import gspq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   action_id;
  logic [ID_W-1:0]   state_id;
  logic              state_on;
  logic [PRIO_W-1:0] priority_req;
  logic              allow_repeat;

  modport source (output valid, func, action_id, state_id, state_on, priority_req,
                  allow_repeat, input ready);
  modport sink   (input valid, func, action_id, state_id, state_on, priority_req,
                  allow_repeat, output ready);
endinterface

interface gspq_out_if import gspq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [ID_W-1:0]   out_action;
  logic              accepted;
  logic [QCNT_W-1:0] queue_count;
  logic [ACNT_W-1:0] active_count;

  modport source (output valid, found, out_action, accepted, queue_count, active_count,
                  input ready);
  modport sink   (input valid, found, out_action, accepted, queue_count, active_count,
                  output ready);
endinterface

// ===== rtl/core/gspq_cell.sv =====
module gspq_cell import gspq_pkg::*; (
  input  logic        clk,
  input  gspq_bcast_t bcast,
  input  logic        occ,
  input  gspq_link_t  left,
  output gspq_link_t  link,
  output logic        dup
);

  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;

  assign link.le   = occ && (prio_r <= bcast.prio);
  assign link.id   = id_r;
  assign link.prio = prio_r;
  assign dup       = occ && (prio_r == bcast.prio) && (id_r == bcast.id);

  // shift up one place when the new entry lands at or below this cell
  always_ff @(posedge clk) begin
    if (bcast.ins_en && !link.le) begin
      if (left.le) begin
        id_r   <= bcast.id;
        prio_r <= bcast.prio;
      end else begin
        id_r   <= left.id;
        prio_r <= left.prio;
      end
    end
  end

endmodule

// ===== rtl/core/gspq_attr.sv =====
module gspq_attr import gspq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [ACT_IDX_W-1:0] rd_idx,
  output logic [PRIO_W-1:0]    rd_prio_r,
  output logic                 rd_rep_r,
  input  logic                 wr_en,
  input  logic [ACT_IDX_W-1:0] wr_idx,
  input  logic [PRIO_W-1:0]    wr_prio,
  input  logic                 wr_rep
);

  logic [PRIO_W-1:0] prio_r [ACTION_COUNT];
  logic              rep_r  [ACTION_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ACTION_COUNT; i++) begin
        prio_r[i] <= '0;
        rep_r[i]  <= 1'b0;
      end
    end else if (wr_en) begin
      prio_r[wr_idx] <= wr_prio;
      rep_r[wr_idx]  <= wr_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_prio_r <= prio_r[rd_idx];
      rd_rep_r  <= rep_r[rd_idx];
    end
  end

endmodule

// ===== rtl/core/gated_sorted_priority_queue.sv =====
// results: the request is registered at the input beat and executes once the output
//   register is free; its result is then registered and offered on out_chan
// an input beat is taken only in the idle state; attribute lookup at the input beat,
//   compare and shift-insert across the cell chain when the request executes
// a waiting result does not stop the next input beat from being taken
// reset: synchronous active-low rst_n empties the queue, clears the blocking states, their
//   count and every action's priority and repeat flag
module gated_sorted_priority_queue import gspq_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  gspq_in_if.sink   in_chan,
  gspq_out_if.source out_chan
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  logic [FUNC_W-1:0]     func_r;
  logic [ID_W-1:0]       aid_r;
  logic                  aid_ok_r;
  logic [ST_IDX_W-1:0]   sidx_r;
  logic                  sid_ok_r;
  logic                  on_r;
  logic [PRIO_W-1:0]     preq_r;
  logic                  arep_r;

  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [STATE_COUNT-1:0] st_bits_r, st_bits_nxt;
  logic [BLK_W-1:0]       blk_r, blk_nxt;

  logic                  out_valid_r;
  logic                  found_r;
  logic [ID_W-1:0]       act_r;
  logic                  acc_r;
  logic [LEN_W-1:0]      qcnt_r;
  logic [BLK_W-1:0]      acnt_r;

  logic [AID_EXT_W-1:0]  aid_ext;
  logic [SID_EXT_W-1:0]  sid_ext;
  logic                  in_beat;
  logic                  go;
  logic [PRIO_W-1:0]     look_prio;
  logic                  look_rep;
  logic                  full;
  logic                  dup_any;
  logic                  enq_ok;
  logic                  deq_ok;
  logic                  st_set;
  logic                  st_clr;
  logic [QIDX_W-1:0]     tail_idx;

  gspq_bcast_t           bcast;
  gspq_link_t            lnk [QUEUE_DEPTH];
  gspq_link_t            head_link;
  logic [QUEUE_DEPTH-1:0] dup;
  logic [QUEUE_DEPTH-1:0] occ;

  assign aid_ext  = AID_EXT_W'(in_chan.action_id);
  assign sid_ext  = SID_EXT_W'(in_chan.state_id);
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_beat  = in_chan.valid && in_chan.ready;
  assign go       = (state_r == ST_EXEC) && (!out_valid_r || out_chan.ready);

  gspq_attr u_attr (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_beat),
    .rd_idx    (aid_ext[ACT_IDX_W-1:0]),
    .rd_prio_r (look_prio),
    .rd_rep_r  (look_rep),
    .wr_en     (go && (func_r == FUNC_ATTR) && aid_ok_r),
    .wr_idx    (ACT_IDX_W'(aid_r)),
    .wr_prio   (preq_r),
    .wr_rep    (arep_r)
  );

  // cell chain, entry 0 holds the lowest priority
  assign head_link = '{le: 1'b1, id: '0, prio: '0};
  assign bcast     = '{ins_en: go && enq_ok, id: aid_r, prio: look_prio};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occ[i] = (LEN_W'(i) < len_r);
    gspq_cell u_cell (
      .clk   (clk),
      .bcast (bcast),
      .occ   (occ[i]),
      .left  ((i == 0) ? head_link : lnk[(i == 0) ? 0 : i - 1]),
      .link  (lnk[i]),
      .dup   (dup[i])
    );
  end

  assign dup_any  = |dup;
  assign full     = (len_r == LEN_W'(QUEUE_DEPTH));
  assign enq_ok   = (func_r == FUNC_ENQ) && aid_ok_r && !full && !(dup_any && !look_rep);
  assign deq_ok   = (func_r == FUNC_DEQ) && (blk_r == '0) && (len_r != '0);
  assign st_set   = (func_r == FUNC_SET) && sid_ok_r && on_r && !st_bits_r[sidx_r];
  assign st_clr   = (func_r == FUNC_SET) && sid_ok_r && !on_r && st_bits_r[sidx_r];
  assign tail_idx = QIDX_W'(len_r - LEN_W'(1));

  always_comb begin
    len_nxt     = len_r;
    blk_nxt     = blk_r;
    st_bits_nxt = st_bits_r;
    if (enq_ok) begin
      len_nxt = len_r + LEN_W'(1);
    end else if (deq_ok) begin
      len_nxt = len_r - LEN_W'(1);
    end
    if (st_set) begin
      st_bits_nxt[sidx_r] = 1'b1;
      blk_nxt             = blk_r + BLK_W'(1);
    end else if (st_clr) begin
      st_bits_nxt[sidx_r] = 1'b0;
      blk_nxt             = blk_r - BLK_W'(1);
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = in_beat ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = go ? ST_IDLE : ST_EXEC;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      blk_r       <= '0;
      st_bits_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        len_r       <= len_nxt;
        blk_r       <= blk_nxt;
        st_bits_r   <= st_bits_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      func_r   <= in_chan.func;
      aid_r    <= in_chan.action_id;
      aid_ok_r <= ({1'b0, aid_ext} < ACTION_LIMIT);
      sidx_r   <= sid_ext[ST_IDX_W-1:0];
      sid_ok_r <= ({1'b0, sid_ext} < STATE_LIMIT);
      on_r     <= in_chan.state_on;
      preq_r   <= in_chan.priority_req;
      arep_r   <= in_chan.allow_repeat;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      found_r <= deq_ok;
      act_r   <= deq_ok ? lnk[tail_idx].id : '0;
      acc_r   <= enq_ok;
      qcnt_r  <= len_nxt;
      acnt_r  <= blk_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.found        = found_r;
  assign out_chan.out_action   = act_r;
  assign out_chan.accepted     = acc_r;
  assign out_chan.queue_count  = QCNT_W'(qcnt_r);
  assign out_chan.active_count = ACNT_W'(acnt_r);

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(QUEUE_DEPTH))
    else $error("queue length beyond depth");

  a_blk_count: assert property (@(posedge clk) disable iff (!rst_n)
    blk_r == BLK_W'($countones(st_bits_r)))
    else $error("blocking count out of step with state bits");

  a_found_unblocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.found |-> out_chan.active_count == '0)
    else $error("dequeue returned an action while blocked");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !(out_chan.found && out_chan.accepted))
    else $error("result both dequeued and enqueued");

endmodule
